/* hw/rtl/acal_pkg.sv */
// ----------------------------------------------------------------------------
// acal_pkg
// Shared types and constants of the ADC sample calibration pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package acal_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int FRAC_BITS   = 16;
    localparam int COEF_BITS   = 16;
    localparam int VALUE_BITS  = 48;
    localparam int X_BITS      = SAMPLE_BITS + FRAC_BITS;
    localparam int SCALE_BITS  = 2 * COEF_BITS;
    localparam int PROD_BITS   = X_BITS + SCALE_BITS;

    // Full-scale normalisation: n / 4095 via n * 4097 >> 24 plus one correction
    localparam int FULL_SCALE  = 4095;
    localparam int RECIP_MUL   = 4097;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_BITS  = X_BITS + 13;
    localparam int Q_BITS      = RECIP_BITS - RECIP_SHIFT;

    // Divider: quotient bits resolved per stage and stage count
    localparam int DIV_STEP    = 4;
    localparam int DIV_STAGES  = VALUE_BITS / DIV_STEP;

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ADC_REFERENCE = 3'd0,
        REG_GAIN          = 3'd1,
        REG_OFFSET        = 3'd2,
        REG_SHUNT_DIVISOR = 3'd3,
        REG_SQUARE_COEFF  = 3'd4,
        REG_LINEAR_COEFF  = 3'd5,
        REG_CONST_COEFF   = 3'd6,
        REG_NORMALIZE     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [COEF_BITS-1:0] adc_reference;
        logic [COEF_BITS-1:0] gain;
        logic [COEF_BITS-1:0] offset;
        logic [COEF_BITS-1:0] shunt_divisor;
        logic [COEF_BITS-1:0] square_coeff;
        logic [COEF_BITS-1:0] linear_coeff;
        logic [COEF_BITS-1:0] const_coeff;
        logic                 normalize_full_scale;
    } cfg_t;

    // Item travelling between the pipeline sections
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic                  sat;
        logic [VALUE_BITS-1:0] data;
    } item_t;

endpackage

`default_nettype wire

/* hw/rtl/acal_scale.sv */
// ----------------------------------------------------------------------------
// acal_scale
// Full-scale normalisation, reference/gain scaling and offset, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module acal_scale
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              en,
    input  wire logic                              in_valid,
    input  wire logic [acal_pkg::SAMPLE_BITS-1:0]  in_sample,
    input  wire logic                              in_last,
    input  wire acal_pkg::cfg_t                    cfg,
    output acal_pkg::item_t                        out_item
);

    logic [3:0] valid_reg;

    // stage 1
    logic [acal_pkg::SAMPLE_BITS-1:0] s1_sample_reg;
    logic [acal_pkg::Q_BITS-1:0]      s1_q0_reg;
    logic                             s1_last_reg;
    // stage 2
    logic [acal_pkg::X_BITS-1:0]      s2_x_reg;
    logic                             s2_last_reg;
    // stage 3
    logic [acal_pkg::PROD_BITS-1:0]   s3_prod_reg;
    logic                             s3_last_reg;
    // stage 4
    acal_pkg::item_t                  s4_reg;

    logic [acal_pkg::SCALE_BITS-1:0]  scale_reg;

    logic [acal_pkg::X_BITS-1:0]      n_in;
    logic [acal_pkg::RECIP_BITS-1:0]  recip_next;
    logic [acal_pkg::X_BITS-1:0]      n_s1;
    logic [acal_pkg::X_BITS:0]        q0_times;
    logic [acal_pkg::X_BITS:0]        rem;
    logic [acal_pkg::Q_BITS-1:0]      q_fix;
    logic [acal_pkg::X_BITS-1:0]      x_next;
    logic [acal_pkg::VALUE_BITS:0]    sum_next;
    logic                             sat_next;

    always_comb
    begin
        n_in       = {in_sample, {acal_pkg::FRAC_BITS{1'b0}}};
        recip_next = acal_pkg::RECIP_BITS'(n_in) *
                     acal_pkg::RECIP_BITS'(acal_pkg::RECIP_MUL);

        n_s1     = {s1_sample_reg, {acal_pkg::FRAC_BITS{1'b0}}};
        // q0 * 4095 as a shift and subtract
        q0_times = (acal_pkg::X_BITS'(s1_q0_reg) << 12) - (acal_pkg::X_BITS+1)'(s1_q0_reg);
        rem      = (acal_pkg::X_BITS+1)'(n_s1) - q0_times;
        q_fix    = s1_q0_reg + ((rem >= (acal_pkg::X_BITS+1)'(acal_pkg::FULL_SCALE))
                                ? acal_pkg::Q_BITS'(1) : acal_pkg::Q_BITS'(0));
        x_next   = cfg.normalize_full_scale ? acal_pkg::X_BITS'(q_fix) : n_s1;

        sat_next = (s3_prod_reg[acal_pkg::PROD_BITS-1:acal_pkg::VALUE_BITS] != '0);
        sum_next = (acal_pkg::VALUE_BITS+1)'(s3_prod_reg[acal_pkg::VALUE_BITS-1:0]) +
                   (acal_pkg::VALUE_BITS+1)'({cfg.offset, {acal_pkg::FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // the user must keep configuration static while items flow; the block does not enforce it
        scale_reg <= cfg.adc_reference * cfg.gain;
        if (en)
        begin
            s1_sample_reg <= in_sample;
            s1_q0_reg     <= recip_next[acal_pkg::RECIP_BITS-1:acal_pkg::RECIP_SHIFT];
            s1_last_reg   <= in_last;
            s2_x_reg      <= x_next;
            s2_last_reg   <= s1_last_reg;
            s3_prod_reg   <= acal_pkg::PROD_BITS'(s2_x_reg) * acal_pkg::PROD_BITS'(scale_reg);
            s3_last_reg   <= s2_last_reg;
            s4_reg.last   <= s3_last_reg;
            s4_reg.sat    <= sat_next | sum_next[acal_pkg::VALUE_BITS];
            s4_reg.data   <= sum_next[acal_pkg::VALUE_BITS-1:0];
        end
    end

    always_comb
    begin
        out_item.valid = valid_reg[3];
        out_item.last  = s4_reg.last;
        out_item.sat   = s4_reg.sat;
        out_item.data  = s4_reg.data;
    end

endmodule

`default_nettype wire

/* hw/rtl/acal_div.sv */
// ----------------------------------------------------------------------------
// acal_div
// Pipelined restoring divider by the shunt divisor, a few quotient bits a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module acal_div
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire acal_pkg::item_t in_item,
    input  wire acal_pkg::cfg_t  cfg,
    output acal_pkg::item_t      out_item
);

    logic [acal_pkg::DIV_STAGES-1:0]  valid_reg;
    logic [acal_pkg::DIV_STAGES-1:0]  last_reg;
    logic [acal_pkg::DIV_STAGES-1:0]  sat_reg;
    logic [acal_pkg::VALUE_BITS-1:0]  dq_reg  [acal_pkg::DIV_STAGES];
    logic [acal_pkg::COEF_BITS-1:0]   rem_reg [acal_pkg::DIV_STAGES];

    logic [acal_pkg::COEF_BITS-1:0]   divisor;

    // zero means no division: divide by one instead
    assign divisor = (cfg.shunt_divisor == '0) ? acal_pkg::COEF_BITS'(1) : cfg.shunt_divisor;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[acal_pkg::DIV_STAGES-2:0], in_item.valid};
        end
    end

    for (genvar g = 0; g < acal_pkg::DIV_STAGES; g++)
    begin : g_stage
        logic [acal_pkg::VALUE_BITS-1:0] dq_in;
        logic [acal_pkg::COEF_BITS-1:0]  rem_in;
        logic [acal_pkg::VALUE_BITS-1:0] dq_next;
        logic [acal_pkg::COEF_BITS-1:0]  rem_next;

        if (g == 0)
        begin : g_first
            assign dq_in  = in_item.data;
            assign rem_in = '0;
        end
        else
        begin : g_rest
            assign dq_in  = dq_reg[g-1];
            assign rem_in = rem_reg[g-1];
        end

        always_comb
        begin
            logic [acal_pkg::COEF_BITS:0] trial;
            dq_next  = dq_in;
            rem_next = rem_in;
            for (int k = 0; k < acal_pkg::DIV_STEP; k++)
            begin
                trial   = {rem_next, dq_next[acal_pkg::VALUE_BITS-1]};
                dq_next = {dq_next[acal_pkg::VALUE_BITS-2:0], 1'b0};
                if (trial >= {1'b0, divisor})
                begin
                    trial      = trial - {1'b0, divisor};
                    dq_next[0] = 1'b1;
                end
                rem_next = trial[acal_pkg::COEF_BITS-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dq_reg[g]  <= dq_next;
                rem_reg[g] <= rem_next;
                if (g == 0)
                begin
                    last_reg[g] <= in_item.last;
                    sat_reg[g]  <= in_item.sat;
                end
                else
                begin
                    last_reg[g] <= last_reg[g-1];
                    sat_reg[g]  <= sat_reg[g-1];
                end
            end
        end
    end

    always_comb
    begin
        out_item.valid = valid_reg[acal_pkg::DIV_STAGES-1];
        out_item.last  = last_reg[acal_pkg::DIV_STAGES-1];
        out_item.sat   = sat_reg[acal_pkg::DIV_STAGES-1];
        out_item.data  = dq_reg[acal_pkg::DIV_STAGES-1];
    end

endmodule

`default_nettype wire

/* hw/rtl/acal_poly.sv */
// ----------------------------------------------------------------------------
// acal_poly
// Quadratic correction with saturation, four stages; last stage is the output.
// ----------------------------------------------------------------------------
`default_nettype none

module acal_poly
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire acal_pkg::item_t in_item,
    input  wire acal_pkg::cfg_t  cfg,
    output acal_pkg::item_t      out_item
);

    localparam int HALF = acal_pkg::VALUE_BITS - acal_pkg::FRAC_BITS;
    localparam int WIDE = acal_pkg::VALUE_BITS + acal_pkg::COEF_BITS;

    logic [3:0] valid_reg;
    logic [3:0] last_reg;

    logic [2*HALF-1:0]                  p1_sq_reg;
    logic [WIDE-1:0]                    p1_lin_reg;
    logic                               p1_sat_reg;
    logic [WIDE-1:0]                    p2_sqc_reg;
    logic [acal_pkg::VALUE_BITS-1:0]    p2_lin_reg;
    logic                               p2_sat_reg;
    logic [acal_pkg::VALUE_BITS-1:0]    p3_sum_reg;
    logic                               p3_sat_reg;
    logic [acal_pkg::VALUE_BITS-1:0]    p4_value_reg;
    logic                               p4_sat_reg;

    logic [acal_pkg::VALUE_BITS:0]      sum1;
    logic [acal_pkg::VALUE_BITS:0]      sum2;
    logic [acal_pkg::VALUE_BITS-1:0]    sq_shifted;

    always_comb
    begin
        sq_shifted = p1_sq_reg[2*HALF-1:acal_pkg::FRAC_BITS];
        sum1 = (acal_pkg::VALUE_BITS+1)'(p2_sqc_reg[acal_pkg::VALUE_BITS-1:0]) +
               (acal_pkg::VALUE_BITS+1)'(p2_lin_reg);
        sum2 = (acal_pkg::VALUE_BITS+1)'(p3_sum_reg) +
               (acal_pkg::VALUE_BITS+1)'({cfg.const_coeff, {acal_pkg::FRAC_BITS{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_item.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_reg     <= {last_reg[2:0], in_item.last};
            // a value of 2^32 or more squares beyond the range
            p1_sq_reg    <= (2*HALF)'(in_item.data[HALF-1:0]) * (2*HALF)'(in_item.data[HALF-1:0]);
            p1_lin_reg   <= WIDE'(in_item.data) * WIDE'(cfg.linear_coeff);
            p1_sat_reg   <= in_item.sat | (in_item.data[acal_pkg::VALUE_BITS-1:HALF] != '0);
            p2_sqc_reg   <= WIDE'(sq_shifted) * WIDE'(cfg.square_coeff);
            p2_lin_reg   <= p1_lin_reg[acal_pkg::VALUE_BITS-1:0];
            p2_sat_reg   <= p1_sat_reg | (p1_lin_reg[WIDE-1:acal_pkg::VALUE_BITS] != '0);
            p3_sum_reg   <= sum1[acal_pkg::VALUE_BITS-1:0];
            p3_sat_reg   <= p2_sat_reg | sum1[acal_pkg::VALUE_BITS] |
                            (p2_sqc_reg[WIDE-1:acal_pkg::VALUE_BITS] != '0);
            p4_sat_reg   <= p3_sat_reg | sum2[acal_pkg::VALUE_BITS];
            p4_value_reg <= (p3_sat_reg | sum2[acal_pkg::VALUE_BITS]) ? '1
                            : sum2[acal_pkg::VALUE_BITS-1:0];
        end
    end

    always_comb
    begin
        out_item.valid = valid_reg[3];
        out_item.last  = last_reg[3];
        out_item.sat   = p4_sat_reg;
        out_item.data  = p4_value_reg;
    end

endmodule

`default_nettype wire

/* hw/rtl/adc_sample_calibration.sv */
// ----------------------------------------------------------------------------
// adc_sample_calibration
// Calibrates raw ADC samples into unsigned Q32.16 values with saturation.
// ----------------------------------------------------------------------------
// Takes one sample per clock while the output is not stalled and returns one
// result per sample, in order. A result passes through twenty register
// stages: four of normalisation and scaling, twelve divider stages resolving
// four quotient bits each, four of quadratic correction. The whole pipeline
// holds while a result waits at the output.
// Write configuration only while idle.
`default_nettype none

module adc_sample_calibration
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [15:0]                        s_tdata,   // [11:0] sample
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [acal_pkg::VALUE_BITS-1:0]         m_tdata,   // [47:0] value
    output logic                                    m_tuser,   // [0] saturated
    output logic                                    m_tlast,
    input  wire logic                               cfg_we,
    input  wire logic [acal_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [acal_pkg::COEF_BITS-1:0]     cfg_data
);

    acal_pkg::cfg_t  cfg_reg;
    acal_pkg::item_t scale_item;
    acal_pkg::item_t div_item;
    acal_pkg::item_t poly_item;
    logic            advance;

    // advance every stage unless a result is waiting
    assign advance  = !poly_item.valid || m_tready;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_reference        <= acal_pkg::COEF_BITS'(1);
            cfg_reg.gain                 <= acal_pkg::COEF_BITS'(1);
            cfg_reg.offset               <= '0;
            cfg_reg.shunt_divisor        <= '0;
            cfg_reg.square_coeff         <= '0;
            cfg_reg.linear_coeff         <= acal_pkg::COEF_BITS'(1);
            cfg_reg.const_coeff          <= '0;
            cfg_reg.normalize_full_scale <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (acal_pkg::cfg_idx_t'(cfg_index))
                acal_pkg::REG_ADC_REFERENCE: cfg_reg.adc_reference <= cfg_data;
                acal_pkg::REG_GAIN:          cfg_reg.gain          <= cfg_data;
                acal_pkg::REG_OFFSET:        cfg_reg.offset        <= cfg_data;
                acal_pkg::REG_SHUNT_DIVISOR: cfg_reg.shunt_divisor <= cfg_data;
                acal_pkg::REG_SQUARE_COEFF:  cfg_reg.square_coeff  <= cfg_data;
                acal_pkg::REG_LINEAR_COEFF:  cfg_reg.linear_coeff  <= cfg_data;
                acal_pkg::REG_CONST_COEFF:   cfg_reg.const_coeff   <= cfg_data;
                acal_pkg::REG_NORMALIZE:     cfg_reg.normalize_full_scale <= cfg_data[0];
                default: ;
            endcase
        end
    end

    acal_scale u_scale
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s_tvalid),
        .in_sample (s_tdata[acal_pkg::SAMPLE_BITS-1:0]),
        .in_last   (s_tlast),
        .cfg       (cfg_reg),
        .out_item  (scale_item)
    );

    acal_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_item  (scale_item),
        .cfg      (cfg_reg),
        .out_item (div_item)
    );

    acal_poly u_poly
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_item  (div_item),
        .cfg      (cfg_reg),
        .out_item (poly_item)
    );

    assign m_tvalid = poly_item.valid;
    assign m_tdata  = poly_item.data;
    assign m_tuser  = poly_item.sat;
    assign m_tlast  = poly_item.last;

`ifndef SYNTH
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '1)
        else $error("saturated result is not full scale");

    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(div_item) && $stable(scale_item))
        else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

/* dv/adc_sample_calibration_tb.sv */
// ----------------------------------------------------------------------------
// adc_sample_calibration_tb
// Self-checking bench for the ADC sample calibration pipeline.
// ----------------------------------------------------------------------------
// Drives raw samples through the stream input with random gaps and output
// stalls, predicts each calibrated value with a 128-bit arithmetic model and
// compares value, saturation flag and block marker in transfer order. The run
// moves through several register settings, written only while idle.
`timescale 1ns / 1ps

module adc_sample_calibration_tb;

    localparam logic [47:0] VMAX = {48{1'b1}};
    localparam int WATCHDOG = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [acal_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [acal_pkg::COEF_BITS-1:0]    cfg_data = '0;

    typedef struct {
        logic [47:0] value;
        logic        sat;
        logic        last;
    } cal_result_t;

    cal_result_t     pending_q[$];
    acal_pkg::cfg_t  regs;
    int              mismatches = 0;
    int              idle_cycles = 0;
    int              stall_left = 0;

    adc_sample_calibration dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Saturating (a*b) >> sh on a full 128-bit product
    function automatic logic [47:0] mul_sat(logic [63:0] a, logic [63:0] b, int sh,
                                            inout bit sat);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        if (p > {80'd0, VMAX})
        begin
            sat = 1'b1;
            return VMAX;
        end
        return p[47:0];
    endfunction

    function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b, inout bit sat);
        logic [48:0] r;
        r = {1'b0, a} + {1'b0, b};
        if (r[48])
        begin
            sat = 1'b1;
            return VMAX;
        end
        return r[47:0];
    endfunction

    function automatic cal_result_t calibrate(logic [11:0] sample, logic last);
        cal_result_t r;
        bit          sat;
        logic [63:0] x;
        logic [47:0] y;
        logic [47:0] sq;
        logic [47:0] lin;
        sat = 1'b0;
        x = {52'd0, sample} << acal_pkg::FRAC_BITS;
        if (regs.normalize_full_scale)
            x = x / 64'(acal_pkg::FULL_SCALE);
        y = mul_sat(x, {48'd0, regs.adc_reference} * {48'd0, regs.gain}, 0, sat);
        y = add_sat(y, {32'd0, regs.offset} << acal_pkg::FRAC_BITS, sat);
        if (regs.shunt_divisor != '0)
            y = y / {32'd0, regs.shunt_divisor};
        sq  = mul_sat({16'd0, y}, {16'd0, y}, acal_pkg::FRAC_BITS, sat);
        sq  = mul_sat({16'd0, sq}, {48'd0, regs.square_coeff}, 0, sat);
        lin = mul_sat({16'd0, y}, {48'd0, regs.linear_coeff}, 0, sat);
        y   = add_sat(sq, lin, sat);
        y   = add_sat(y, {32'd0, regs.const_coeff} << acal_pkg::FRAC_BITS, sat);
        r.value = sat ? VMAX : y;
        r.sat   = sat;
        r.last  = last;
        return r;
    endfunction

    task automatic write_reg(acal_pkg::cfg_idx_t idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            acal_pkg::REG_ADC_REFERENCE: regs.adc_reference = val;
            acal_pkg::REG_GAIN:          regs.gain = val;
            acal_pkg::REG_OFFSET:        regs.offset = val;
            acal_pkg::REG_SHUNT_DIVISOR: regs.shunt_divisor = val;
            acal_pkg::REG_SQUARE_COEFF:  regs.square_coeff = val;
            acal_pkg::REG_LINEAR_COEFF:  regs.linear_coeff = val;
            acal_pkg::REG_CONST_COEFF:   regs.const_coeff = val;
            acal_pkg::REG_NORMALIZE:     regs.normalize_full_scale = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(logic [15:0] ref_v, logic [15:0] gain_v, logic [15:0] off_v,
                             logic [15:0] shunt_v, logic [15:0] sq_v, logic [15:0] lin_v,
                             logic [15:0] const_v, logic [15:0] norm_v);
        write_reg(acal_pkg::REG_ADC_REFERENCE, ref_v);
        write_reg(acal_pkg::REG_GAIN, gain_v);
        write_reg(acal_pkg::REG_OFFSET, off_v);
        write_reg(acal_pkg::REG_SHUNT_DIVISOR, shunt_v);
        write_reg(acal_pkg::REG_SQUARE_COEFF, sq_v);
        write_reg(acal_pkg::REG_LINEAR_COEFF, lin_v);
        write_reg(acal_pkg::REG_CONST_COEFF, const_v);
        write_reg(acal_pkg::REG_NORMALIZE, norm_v);
    endtask

    function automatic int gap_len();
        return int'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                 : $urandom_range(0, 2));
    endfunction

    // Hold one sample on the bus until it is taken; prediction uses current regs
    task automatic send_sample(logic [15:0] data, logic last, bit pace);
        int g;
        g = pace ? gap_len() : 0;
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_q.push_back(calibrate(data[11:0], last));
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // Output stalls: mostly short, occasionally long
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= gap_len();
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cal_result_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%h sat=%b last=%b",
                             m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = pending_q.pop_front();
                if (m_tdata !== want.value || m_tuser !== want.sat || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp value=%h sat=%b last=%b got value=%h sat=%b last=%b",
                                 want.value, want.sat, want.last, m_tdata, m_tuser, m_tlast);
                end
            end
        end
        if (idle_cycles >= WATCHDOG)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    typedef struct {
        logic [15:0] data;
        logic        last;
        bit          known;
        logic [47:0] value;
        logic        sat;
    } stim_row_t;

    stim_row_t directed[$];

    initial
    begin
        cal_result_t got;
        int          n;
        regs = '{adc_reference: 16'd1, gain: 16'd1, offset: 16'd0, shunt_divisor: 16'd0,
                 square_coeff: 16'd0, linear_coeff: 16'd1, const_coeff: 16'd0,
                 normalize_full_scale: 1'b1};
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // After reset: normalised sample, unity chain; full scale gives exactly 1.0
        directed.push_back('{16'h0000, 1'b0, 1'b1, 48'd0, 1'b0});
        directed.push_back('{16'h0FFF, 1'b1, 1'b1, 48'h10000, 1'b0});
        directed.push_back('{16'hF001, 1'b0, 1'b0, 48'd0, 1'b0});
        directed.push_back('{16'h0800, 1'b1, 1'b0, 48'd0, 1'b0});
        directed.push_back('{16'h0555, 1'b0, 1'b0, 48'd0, 1'b0});
        foreach (directed[i])
        begin
            if (directed[i].known)
            begin
                got = calibrate(directed[i].data[11:0], directed[i].last);
                if (got.value !== directed[i].value || got.sat !== directed[i].sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("table row %0d exp value=%h sat=%b predicted value=%h sat=%b",
                                 i, directed[i].value, directed[i].sat, got.value, got.sat);
                end
            end
            send_sample(directed[i].data, directed[i].last, 1'b0);
        end
        drain();

        // Raw counts, large scaling: saturation on full scale
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        send_sample(16'h0FFF, 1'b1, 1'b0);
        send_sample(16'h0000, 1'b0, 1'b0);
        send_sample(16'h0001, 1'b0, 1'b0);
        drain();
        // Zero reference, gain and linear coefficient; offset, shunt division, square and constant terms
        write_all(16'd0, 16'd0, 16'd100, 16'd7, 16'd3, 16'd0, 16'd5, 16'd1);
        send_sample(16'h0FFF, 1'b0, 1'b0);
        send_sample(16'hAAAA, 1'b1, 1'b0);
        drain();
        // Shunt divisor at maximum and at one
        write_all(16'd300, 16'd200, 16'd1, 16'hFFFF, 16'd1, 16'd2, 16'd0, 16'd0);
        send_sample(16'h0FFF, 1'b0, 1'b0);
        send_sample(16'h5555, 1'b1, 1'b0);
        drain();
        write_reg(acal_pkg::REG_SHUNT_DIVISOR, 16'd1);
        send_sample(16'h0123, 1'b0, 1'b0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: write_all(16'($urandom_range(0, 15)), 16'($urandom_range(0, 15)),
                             16'($urandom_range(0, 255)), 16'($urandom_range(0, 3)),
                             16'($urandom_range(0, 3)), 16'($urandom_range(0, 15)),
                             16'($urandom), 16'($urandom_range(0, 1)));
                1: write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
                2: write_all(16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                             16'($urandom), 16'($urandom_range(1, 1000)),
                             16'($urandom_range(0, 4)), 16'($urandom),
                             16'($urandom), 16'd1);
                default: write_all(16'hFFFF, 16'($urandom_range(0, 3)), 16'd0, 16'd0,
                                   16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
            endcase
            n = int'($urandom_range(40, 60));
            for (int k = 0; k < n; k++)
                send_sample(16'($urandom), 1'($urandom_range(0, 1)),
                            (phase % 2) == 0 || k < 20);
            drain();
        end

        if (mismatches == 0 && pending_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* adc_sample_calibration.f */
hw/rtl/acal_pkg.sv
hw/rtl/acal_scale.sv
hw/rtl/acal_div.sv
hw/rtl/acal_poly.sv
hw/rtl/adc_sample_calibration.sv
dv/adc_sample_calibration_tb.sv
